/* rtl/core/tfd_pkg.sv */
package tfd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_BODY    = 2'd2,
        PH_TRAILER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_PHASE  = 2'd0,
        ERR_SEQ    = 2'd1,
        ERR_LENGTH = 2'd2,
        ERR_SUM    = 2'd3
    } err_code_t;

    // phase nibble as carried on the link
    localparam logic [3:0] WPH_NONE    = 4'd0;
    localparam logic [3:0] WPH_HEADER  = 4'd1;
    localparam logic [3:0] WPH_BODY    = 4'd2;
    localparam logic [3:0] WPH_TRAILER = 4'd3;

    localparam logic [7:0] ABORT_HI      = 8'h3f;
    localparam logic [3:0] SEQ_LAST_TAG  = 4'd3;
    localparam logic [3:0] SEQ_LAST_LEN  = 4'd7;
    localparam logic [3:0] SEQ_LAST_HDR  = 4'd15;
    localparam logic [3:0] SEQ_TRL_END   = 4'd4;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  expected_seq;
        logic [31:0] running_sum;
        logic [31:0] declared_length;
        logic [31:0] bytes_received;
        logic [31:0] tag_store;
    } frame_state_t;

    typedef struct packed {
        logic        discarded;
        err_code_t   error_code;
        logic        error_flag;
        logic [31:0] app_tag;
        logic        frame_done;
        logic [7:0]  body_byte;
        logic        body_valid;
    } frame_result_t;

endpackage

/* rtl/core/tfd_step.sv */
module tfd_step
    import tfd_pkg::*;
(
    input  frame_state_t  cur,
    input  logic          port_active,
    input  logic [15:0]   word,
    output frame_state_t  nxt,
    output frame_result_t res
);

    logic [3:0]  ph;
    logic [3:0]  seq;
    logic [7:0]  data;
    logic [31:0] shifted;
    logic [31:0] sum_add;
    logic [31:0] tag_or;
    logic [31:0] br_inc;
    logic [3:0]  seq_inc;

    assign ph   = word[15:12];
    assign seq  = word[11:8];
    assign data = word[7:0];

    always_comb
    begin
        case (seq[1:0])
            2'd0:    shifted = {24'd0, data};
            2'd1:    shifted = {16'd0, data, 8'd0};
            2'd2:    shifted = {8'd0, data, 16'd0};
            default: shifted = {data, 24'd0};
        endcase
    end

    assign sum_add = cur.running_sum + shifted;
    assign tag_or  = cur.tag_store | shifted;
    assign br_inc  = (cur.bytes_received == 32'hffff_ffff) ? cur.bytes_received
                                                            : cur.bytes_received + 32'd1;
    assign seq_inc = cur.expected_seq + 4'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (!port_active || word[15:8] == ABORT_HI) begin
            res.discarded   = (cur.phase != PH_IDLE);
            nxt.phase       = PH_IDLE;
            nxt.running_sum = '0;
        end else begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    if (ph != WPH_NONE) begin
                        nxt.running_sum = sum_add;
                        if (ph == WPH_HEADER) begin
                            nxt.expected_seq   = '0;
                            nxt.bytes_received = '0;
                            nxt.phase          = PH_HEADER;
                            if (seq != 4'd0) begin
                                res.error_flag = 1'b1;
                                res.error_code = ERR_SEQ;
                            end else begin
                                nxt.tag_store       = {24'd0, data};
                                nxt.declared_length = '0;
                            end
                        end else begin
                            res.error_flag = 1'b1;
                            res.error_code = ERR_PHASE;
                        end
                    end
                end
                PH_HEADER:
                begin
                    nxt.running_sum = sum_add;
                    if (ph != WPH_HEADER) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_PHASE;
                    end else begin
                        nxt.expected_seq = seq_inc;
                        if (seq != seq_inc) begin
                            res.error_flag = 1'b1;
                            res.error_code = ERR_SEQ;
                        end else if (seq <= SEQ_LAST_TAG) begin
                            nxt.tag_store = tag_or;
                        end else if (seq <= SEQ_LAST_LEN) begin
                            nxt.declared_length = {data, cur.declared_length[31:8]};
                        end else if (seq == SEQ_LAST_HDR) begin
                            nxt.phase        = PH_BODY;
                            nxt.expected_seq = '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    nxt.running_sum = sum_add;
                    if (ph != WPH_BODY) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_PHASE;
                    end else if (seq != cur.expected_seq) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_SEQ;
                    end else begin
                        nxt.expected_seq   = seq_inc;
                        res.body_valid     = 1'b1;
                        res.body_byte      = data;
                        nxt.bytes_received = br_inc;
                        if (br_inc >= cur.declared_length) begin
                            nxt.phase        = PH_TRAILER;
                            nxt.expected_seq = '0;
                        end
                    end
                end
                PH_TRAILER:
                begin
                    if (ph != WPH_TRAILER) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_PHASE;
                    end else if (seq != cur.expected_seq) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_SEQ;
                    end else if (cur.bytes_received != cur.declared_length) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_LENGTH;
                    end else if (data != cur.running_sum[7:0]) begin
                        res.error_flag = 1'b1;
                        res.error_code = ERR_SUM;
                    end else begin
                        nxt.running_sum  = {8'd0, cur.running_sum[31:8]};
                        nxt.expected_seq = seq_inc;
                        if (seq_inc == SEQ_TRL_END) begin
                            nxt.phase       = PH_IDLE;
                            nxt.running_sum = '0;
                            res.frame_done  = 1'b1;
                            res.app_tag     = cur.tag_store;
                        end
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
            // any error drops back to idle with a clean sum
            if (res.error_flag) begin
                nxt.phase       = PH_IDLE;
                nxt.running_sum = '0;
            end
        end
    end

endmodule

/* rtl/core/tagged_frame_deframer_checker_unit.sv */
// Tagged frame deframer and checker.
// Input stream: one link word per transfer on s_axis (tdata = word,
// tuser = port_active). Output stream: one result per input word on m_axis.
// Frame state (phase, sequence, checksum, length, id) advances on every
// accepted word; body bytes, done with the application id, errors and
// discards are reported on the matching result.
// Results are registered: each reaches m_axis from the result register, via the skid register when m_axis stalls.
// Throughput: 1 word per cycle while s_axis_tready is high; the state update is one compare/add pass.
// A result register plus a one-entry skid register sit on the output, so one
// further word is taken while a result waits; s_axis_tready drops only when
// both hold results, and rises again once m_axis drains.
// Reset (rst_n low, asynchronous): frame idle, all counters, sum, length and
// id cleared, both output registers empty.
module tagged_frame_deframer_checker_unit
    import tfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] word
    input  logic                  s_axis_tuser,  // [0] port_active
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] body_valid, [8:1] body_byte, [9] frame_done, [41:10] app_tag,
    // [42] error_flag, [44:43] error_code, [45] discarded, [47:46] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    frame_state_t  state_reg, state_next;
    frame_result_t step_res;
    frame_result_t out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          in_xfer, out_free;

    tfd_step u_step (
        .cur         (state_reg),
        .port_active (s_axis_tuser),
        .word        (s_axis_tdata),
        .nxt         (state_next),
        .res         (step_res)
    );

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_xfer;
                end
            end else if (in_xfer) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_xfer) begin
                out_reg <= step_res;
            end
        end else if (in_xfer) begin
            skid_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

endmodule

/* rtl/core/tfd_checker.sv */
module tfd_checker
    import tfd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
        else $error("pad bits set");

    a_body_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[42]))
        else $error("body byte with error");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |->
            !m_axis_tdata[42] && !m_axis_tdata[0] && !m_axis_tdata[45])
        else $error("done mixed with other events");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[42] |->
            m_axis_tdata[44:43] == 2'b00 && (m_axis_tdata[0] || m_axis_tdata[8:1] == 8'd0))
        else $error("stray code or byte");

endmodule

bind tagged_frame_deframer_checker_unit tfd_checker u_tfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
